[sv/bil_pkg.sv]
// bil_pkg: shared types and constants of the bounded identifier list.
// Used by the list cells, the top level and the port checker.
`timescale 1ns / 1ps

package bil_pkg;

    localparam int MAX_ENTRIES = 8;
    localparam int ID_WIDTH    = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam logic [2:0] MODE_CLEAR      = 3'd0;
    localparam logic [2:0] MODE_ADD        = 3'd1;
    localparam logic [2:0] MODE_FIND       = 3'd2;
    localparam logic [2:0] MODE_REMOVE_ID  = 3'd3;
    localparam logic [2:0] MODE_REMOVE_POS = 3'd4;
    localparam logic [2:0] MODE_READ       = 3'd5;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] ident;
        logic [2:0]  position;
    } req_t;

    typedef struct packed {
        logic        ok;
        logic [2:0]  found_index;
        logic [15:0] entry_value;
        logic [3:0]  entry_count;
    } rsp_t;

    // Broadcast from the sequencer to every cell of the chain.
    typedef struct packed {
        logic                load;
        logic                shift;
        logic                by_pos;
        logic [ID_WIDTH-1:0] ident;
        logic [IDX_W-1:0]    position;
        logic [CNT_W-1:0]    count;
    } cell_ctrl_t;

endpackage

[sv/bil_cell.sv]
// bil_cell: one slot of the list. Holds an identifier, compares it and
// passes the hit chain and shift data to its neighbors. Depends on bil_pkg.
`timescale 1ns / 1ps

module bil_cell (
    input  logic                           clk,
    input  bil_pkg::cell_ctrl_t            ctrl,
    input  logic [bil_pkg::IDX_W-1:0]      idx,
    input  logic                           hit_in,
    input  logic [bil_pkg::ID_WIDTH-1:0]   shift_in,
    output logic                           hit_out,
    output logic                           first,
    output logic [bil_pkg::ID_WIDTH-1:0]   value
);

    logic [bil_pkg::ID_WIDTH-1:0] value_reg;
    logic [bil_pkg::ID_WIDTH-1:0] value_next;
    logic                         active;
    logic                         self_hit;

    assign active   = bil_pkg::CNT_W'(idx) < ctrl.count;
    assign self_hit = ctrl.by_pos ? (idx == ctrl.position)
                                  : (active && (value_reg == ctrl.ident));
    assign hit_out  = hit_in | self_hit;
    assign first    = self_hit & ~hit_in;
    assign value    = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.load && (bil_pkg::CNT_W'(idx) == ctrl.count))
        begin
            value_next = ctrl.ident;
        end
        else if (ctrl.shift && hit_out)
        begin
            value_next = shift_in;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

[sv/bounded_id_list_unit.sv]
// bounded_id_list_unit: top level of the bounded identifier list.
// Instantiates the bil_cell chain; depends on bil_pkg.
`timescale 1ns / 1ps

// Usage
// - Request channel (req_valid / req_stall / req_data): one operation per
//   request: clear, add, find, remove by id, remove by position, read.
//   A request is taken at a clock edge with req_valid high and req_stall low.
// - Response channel (rsp_valid / rsp_stall / rsp_data): exactly one
//   response per request, in order, held in an output register while the
//   receiver stalls.
// - Timing: a request is registered when taken and executed in the run
//   state; its response is written to the response register as it finishes.
//   Remove by id drops one matching entry per cycle through the cell chain,
//   by the chain's single left shift per cycle, and then finishes.
// - req_stall is high while an operation is in flight, one request at a
//   time; a stalled response delays only the final step of the next request.
// - Reset clears the entry count and the response valid flag; slot contents
//   are not reset, and slots at or above the count are never observed.
module bounded_id_list_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  bil_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output bil_pkg::rsp_t rsp_data
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t                       state_reg, state_next;
    bil_pkg::req_t                req_reg;
    logic                         nonempty_reg;
    logic [bil_pkg::CNT_W-1:0]    count_reg, count_next;
    bil_pkg::rsp_t                rsp_reg, rsp_next;
    logic                         rsp_valid_reg, rsp_valid_next;

    bil_pkg::cell_ctrl_t          ctrl;
    logic [bil_pkg::MAX_ENTRIES:0]   hit;
    logic [bil_pkg::MAX_ENTRIES-1:0] first;
    logic [bil_pkg::ID_WIDTH-1:0]    cell_val [bil_pkg::MAX_ENTRIES];

    logic                         accept;
    logic                         running;
    logic                         out_free;
    logic                         shifting;
    logic                         finish;
    logic                         pos_ok;
    logic                         room;
    logic [bil_pkg::IDX_W-1:0]    found_idx;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign running   = (state_reg == ST_RUN);
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    assign pos_ok = bil_pkg::CNT_W'(req_reg.position) < count_reg;
    assign room   = count_reg < bil_pkg::CNT_W'(bil_pkg::MAX_ENTRIES);

    // Remove by id walks the chain: one lowest match dropped per cycle.
    assign shifting = running && (req_reg.mode == bil_pkg::MODE_REMOVE_ID) &&
                      hit[bil_pkg::MAX_ENTRIES];
    assign finish   = running && !shifting && out_free;

    always_comb
    begin
        ctrl.load     = finish && (req_reg.mode == bil_pkg::MODE_ADD) && room;
        ctrl.shift    = shifting ||
                        (finish && (req_reg.mode == bil_pkg::MODE_REMOVE_POS) && pos_ok);
        ctrl.by_pos   = (req_reg.mode == bil_pkg::MODE_REMOVE_POS);
        ctrl.ident    = bil_pkg::ID_WIDTH'(req_reg.ident);
        ctrl.position = bil_pkg::IDX_W'(req_reg.position);
        ctrl.count    = count_reg;
    end

    assign hit[0] = 1'b0;

    for (genvar i = 0; i < bil_pkg::MAX_ENTRIES; i++)
    begin : g_cell
        logic [bil_pkg::ID_WIDTH-1:0] nb;
        if (i == bil_pkg::MAX_ENTRIES - 1)
        begin : g_top
            assign nb = '0;
        end
        else
        begin : g_mid
            assign nb = cell_val[i+1];
        end

        bil_cell u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .idx      (bil_pkg::IDX_W'(i)),
            .hit_in   (hit[i]),
            .shift_in (nb),
            .hit_out  (hit[i+1]),
            .first    (first[i]),
            .value    (cell_val[i])
        );
    end

    // Lowest matching slot: at most one first flag is set.
    always_comb
    begin
        found_idx = '0;
        for (int i = 0; i < bil_pkg::MAX_ENTRIES; i++)
        begin
            if (first[i])
            begin
                found_idx = found_idx | bil_pkg::IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (shifting)
        begin
            count_next = count_reg - 1'b1;
        end
        else if (finish)
        begin
            case (req_reg.mode)
                bil_pkg::MODE_CLEAR:
                begin
                    count_next = '0;
                end
                bil_pkg::MODE_ADD:
                begin
                    if (room)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                bil_pkg::MODE_REMOVE_POS:
                begin
                    if (pos_ok)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        rsp_next             = '0;
        rsp_next.entry_count = 4'(count_next);
        case (req_reg.mode)
            bil_pkg::MODE_CLEAR:
            begin
                rsp_next.ok = 1'b1;
            end
            bil_pkg::MODE_ADD:
            begin
                rsp_next.ok = room;
            end
            bil_pkg::MODE_FIND:
            begin
                rsp_next.ok          = hit[bil_pkg::MAX_ENTRIES];
                rsp_next.found_index = 3'(found_idx);
            end
            bil_pkg::MODE_REMOVE_ID:
            begin
                rsp_next.ok = nonempty_reg;
            end
            bil_pkg::MODE_REMOVE_POS:
            begin
                rsp_next.ok = pos_ok;
            end
            bil_pkg::MODE_READ:
            begin
                rsp_next.ok = pos_ok;
                if (pos_ok)
                begin
                    rsp_next.entry_value =
                        16'(cell_val[bil_pkg::IDX_W'(req_reg.position)]);
                end
            end
            default:
            begin
                rsp_next.ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (finish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg      <= req_data;
            nonempty_reg <= (count_reg != '0);
        end
        if (finish)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule

[sv/bil_checker.sv]
// bil_checker: port-level assertions for bounded_id_list_unit, with bind.
// Depends on bil_pkg.
`timescale 1ns / 1ps

module bil_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input bil_pkg::rsp_t rsp_data
);

    // Stalled response holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("stalled response changed");

    // One request in flight: an accepted request blocks the next cycle.
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while busy");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_data.entry_count <= 4'(bil_pkg::MAX_ENTRIES))
        else $error("entry count above capacity");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.ok |->
            rsp_data.found_index == 3'd0 && rsp_data.entry_value == 16'd0)
        else $error("failed request carries data");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.found_index != 3'd0 |->
            rsp_data.ok && ({1'b0, rsp_data.found_index} < rsp_data.entry_count))
        else $error("found index outside list");

endmodule

bind bounded_id_list_unit bil_checker u_bil_checker (.*);

[dv/tb.sv]
// tb: self-checking testbench for bounded_id_list_unit.
// Holds a list tracker class that predicts each response; depends on bil_pkg.
`timescale 1ns / 1ps

// Tracks the list contents and count as requests are accepted, and keeps
// the responses that are still owed, oldest first.
class list_tracker;
    logic [bil_pkg::ID_WIDTH-1:0] cells[bil_pkg::MAX_ENTRIES];
    int unsigned                  fill;
    bil_pkg::rsp_t                owed_rsps[$];
    int unsigned                  mismatches;

    function new();
        fill       = 0;
        mismatches = 0;
        foreach (cells[i]) cells[i] = '0;
    endfunction

    // Applies one request to the tracked list and returns its response.
    function bil_pkg::rsp_t apply_list_op(bil_pkg::req_t r);
        bil_pkg::rsp_t e;
        int unsigned   idx;
        int unsigned   keep;
        e = '0;
        case (r.mode)
            bil_pkg::MODE_CLEAR:
            begin
                fill = 0;
                e.ok = 1'b1;
            end
            bil_pkg::MODE_ADD:
            begin
                if (fill < bil_pkg::MAX_ENTRIES)
                begin
                    cells[fill] = r.ident;
                    fill++;
                    e.ok = 1'b1;
                end
            end
            bil_pkg::MODE_FIND:
            begin
                for (idx = 0; idx < fill && !e.ok; idx++)
                begin
                    if (cells[idx] == r.ident)
                    begin
                        e.ok          = 1'b1;
                        e.found_index = 3'(idx);
                    end
                end
            end
            bil_pkg::MODE_REMOVE_ID:
            begin
                // succeeds on any non-empty list, match or not
                if (fill > 0)
                begin
                    keep = 0;
                    for (idx = 0; idx < fill; idx++)
                    begin
                        if (cells[idx] != r.ident)
                        begin
                            cells[keep] = cells[idx];
                            keep++;
                        end
                    end
                    fill = keep;
                    e.ok = 1'b1;
                end
            end
            bil_pkg::MODE_REMOVE_POS:
            begin
                if (r.position < fill)
                begin
                    for (idx = r.position; idx + 1 < fill; idx++)
                        cells[idx] = cells[idx + 1];
                    fill--;
                    e.ok = 1'b1;
                end
            end
            bil_pkg::MODE_READ:
            begin
                if (r.position < fill)
                begin
                    e.entry_value = cells[r.position];
                    e.ok          = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        e.entry_count = 4'(fill);
        return e;
    endfunction

    function void note_request(bil_pkg::req_t r);
        owed_rsps = {owed_rsps, apply_list_op(r)};
    endfunction

    function void compare_field(string name, int unsigned exp, int unsigned act);
        if (exp != act)
        begin
            $error("%s: expected %0h, actual %0h", name, exp, act);
            mismatches++;
        end
    endfunction

    function void check_response(bil_pkg::rsp_t got);
        bil_pkg::rsp_t exp;
        if (owed_rsps.size() == 0)
        begin
            $error("response with none outstanding: %0h", got);
            mismatches++;
            return;
        end
        exp = owed_rsps.pop_front();
        compare_field("ok", exp.ok, got.ok);
        compare_field("found_index", exp.found_index, got.found_index);
        compare_field("entry_value", exp.entry_value, got.entry_value);
        compare_field("entry_count", exp.entry_count, got.entry_count);
    endfunction

    function int unsigned pending();
        return owed_rsps.size();
    endfunction
endclass

module tb;

    // Codes outside the six defined operations.
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;

    localparam int RANDOM_PER_PHASE = 488;
    localparam int CYCLE_LIMIT      = 600000;
    // Margin for the slowest case: remove by id on a full list of matches.
    localparam int DRAIN_CYCLES     = 16;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_stall;
    bil_pkg::req_t req_data  = '0;
    logic          rsp_valid;
    logic          rsp_stall = 1'b0;
    bil_pkg::rsp_t rsp_data;

    int unsigned idle_pct  = 0;   // chance the sender sits out a cycle
    int unsigned stall_pct = 0;   // chance the receiver stalls a cycle

    logic [15:0] id_pool[6];      // small set of ids so finds and removes hit

    list_tracker tracker = new();

    bounded_id_list_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Receiver backpressure, redrawn every cycle.
    always @(posedge clk)
        rsp_stall <= ($urandom_range(99) < stall_pct);

    // Handshake monitor: values read here are the ones from before the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
                tracker.check_response(rsp_data);
            if (req_valid && !req_stall)
                tracker.note_request(req_data);
        end
    end

    // Watchdog.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Simulation FAILED");
        $finish;
    end

    // Presents one request and returns at the edge where it is taken.
    // Valid is only lowered when an idle gap is actually inserted, so it
    // never drops and rises within one step.
    task automatic send_request(input logic [2:0] mode, input logic [15:0] ident,
                                input logic [2:0] position);
        bil_pkg::req_t r;
        r.mode     = mode;
        r.ident    = ident;
        r.position = position;
        if ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // Corners: empty list, full list, duplicates, both ends, spare codes.
    task automatic run_directed();
        send_request(bil_pkg::MODE_READ, 16'h0000, 3'd0);        // read on empty list
        send_request(bil_pkg::MODE_FIND, 16'h0000, 3'd0);        // find on empty list
        send_request(bil_pkg::MODE_REMOVE_ID, 16'h0000, 3'd0);   // remove id, empty
        send_request(bil_pkg::MODE_REMOVE_POS, 16'h0000, 3'd0);  // remove pos, empty
        send_request(bil_pkg::MODE_ADD, 16'h0000, 3'd0);
        send_request(bil_pkg::MODE_ADD, 16'hFFFF, 3'd7);
        send_request(bil_pkg::MODE_ADD, 16'hA5A5, 3'd0);
        send_request(bil_pkg::MODE_ADD, 16'h0000, 3'd0);         // duplicate
        send_request(bil_pkg::MODE_ADD, 16'h5A5A, 3'd0);
        send_request(bil_pkg::MODE_ADD, 16'h1234, 3'd0);
        send_request(bil_pkg::MODE_ADD, 16'h0000, 3'd0);
        send_request(bil_pkg::MODE_ADD, 16'hFFFF, 3'd0);         // now full
        send_request(bil_pkg::MODE_ADD, 16'h7777, 3'd0);         // rejected when full
        send_request(bil_pkg::MODE_FIND, 16'h0000, 3'd0);        // lowest of three copies
        send_request(bil_pkg::MODE_FIND, 16'hFFFF, 3'd0);
        send_request(bil_pkg::MODE_FIND, 16'h4321, 3'd0);        // absent
        send_request(bil_pkg::MODE_READ, 16'h0000, 3'd7);
        send_request(bil_pkg::MODE_READ, 16'hFFFF, 3'd0);
        send_request(bil_pkg::MODE_REMOVE_POS, 16'h0000, 3'd7);  // last slot
        send_request(bil_pkg::MODE_REMOVE_POS, 16'h0000, 3'd0);  // first slot
        send_request(bil_pkg::MODE_READ, 16'h0000, 3'd6);        // past the count
        send_request(bil_pkg::MODE_REMOVE_ID, 16'h0000, 3'd0);   // several copies
        send_request(bil_pkg::MODE_REMOVE_ID, 16'h9999, 3'd0);   // no match, still ok
        send_request(MODE_SPARE_6, 16'hFFFF, 3'd7);
        send_request(MODE_SPARE_7, 16'h0000, 3'd0);
        send_request(bil_pkg::MODE_CLEAR, 16'hFFFF, 3'd7);
    endtask

    // Mostly list traffic on a small id pool; adds outweigh removes so the
    // list keeps hitting full, with clears and spare codes as noise.
    task automatic run_random(input int unsigned count);
        int unsigned pick;
        logic [2:0]  mode;
        logic [15:0] ident;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 30)      mode = bil_pkg::MODE_ADD;
            else if (pick < 50) mode = bil_pkg::MODE_FIND;
            else if (pick < 62) mode = bil_pkg::MODE_REMOVE_ID;
            else if (pick < 74) mode = bil_pkg::MODE_REMOVE_POS;
            else if (pick < 94) mode = bil_pkg::MODE_READ;
            else if (pick < 97) mode = bil_pkg::MODE_CLEAR;
            else if (pick < 98) mode = MODE_SPARE_6;
            else                mode = MODE_SPARE_7;
            if ($urandom_range(99) < 70)
                ident = id_pool[$urandom_range(5)];
            else
                ident = 16'($urandom);
            send_request(mode, ident, 3'($urandom_range(7)));
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // Phases: no idling, sender idle, receiver stalling, both.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 86; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 86; end
                default: begin idle_pct = 19; stall_pct = 19; end
            endcase
            id_pool[0] = 16'h0000;
            id_pool[1] = 16'hFFFF;
            for (int k = 2; k < 6; k++)
                id_pool[k] = 16'($urandom);
            run_random(RANDOM_PER_PHASE);
        end

        req_valid <= 1'b0;
        stall_pct = 0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

[bounded_id_list_unit.f]
sv/bil_pkg.sv
sv/bil_cell.sv
sv/bounded_id_list_unit.sv
sv/bil_checker.sv
dv/tb.sv
